[src/ricl_pkg.sv]
// ----------------------------------------------------------------------------
// Image cache package
// Request, status, register and state codes, field widths and the entry
// record that the image cache uses for its table memory.
// ----------------------------------------------------------------------------
`default_nettype none

package ricl_pkg;

  localparam int ID_W       = 16;
  localparam int TEX_W      = 16;
  localparam int REFS_W     = 16;
  localparam int MODE_W     = 2;
  localparam int LIMIT_W    = 6;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd16;
  localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
  localparam logic [REFS_W-1:0]  REFS_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_ASSIGN  = 2'd0,
    REQ_ACQUIRE = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_MISMATCH  = 3'd1,
    STS_DUPLICATE = 3'd2,
    STS_UNKNOWN   = 3'd3,
    STS_UNDERFLOW = 3'd4,
    STS_FULL      = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LRU_LIMIT    = 2'd0,
    CFG_CURRENT_MODE = 2'd1
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_PUSH,
    S_EVICT_CHK,
    S_LRU_PASS,
    S_EVICT_RD,
    S_EVICT_EMIT,
    S_CLR_CHK,
    S_CLR_EMIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   image;
    logic [TEX_W-1:0]  texture;
    logic [REFS_W-1:0] refs;
  } entry_t;

endpackage

`default_nettype wire

[src/ricl_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ricl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/refcounted_image_cache_lru.sv]
// ----------------------------------------------------------------------------
// Reference-counted image cache with LRU eviction
// Assign, acquire and release scan the whole table, then decide; each LRU
// unlink or eviction walks the LRU memory up to lru_count, and an eviction
// then reads the entry and emits it. Clear steps through the slots and
// emits each held image. One request at a time: a new request is taken
// only in idle, once the last one is through.
// Reset clears valid bits and LRU count at once; limit 16, mode 0.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_image_cache_lru
  import ricl_pkg::*;
#(
  parameter int IMAGE_SLOTS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [ID_W-1:0]       image_id_i,
  input  wire logic [TEX_W-1:0]      texture_id_i,
  input  wire logic [MODE_W-1:0]     image_mode_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       release_valid_o,
  output logic [TEX_W-1:0]           released_texture_o,
  output logic [ID_W-1:0]            released_image_o,
  output logic                       last_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SLOT_W  = $clog2(IMAGE_SLOTS);
  localparam int CNT_W   = $clog2(IMAGE_SLOTS + 1);
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(IMAGE_SLOTS);

  state_e state_q, state_d;

  req_e               req_type_q;
  logic [ID_W-1:0]    req_id_q;
  logic [TEX_W-1:0]   req_tex_q;
  status_e            resp_st_q;

  logic [CNT_W-1:0]   cnt_q;
  logic               sc_vld_q;
  logic [SLOT_W-1:0]  sc_idx_q;
  logic               found_q, free_q;
  logic [SLOT_W-1:0]  found_slot_q, free_slot_q, push_slot_q;
  entry_t             ent_q;

  logic               pass_head_q;
  logic [CNT_W-1:0]   pos_q;
  logic               lp_vld_q;
  logic [SLOT_W-1:0]  lp_idx_q;
  logic               hit_q;
  logic [SLOT_W-1:0]  hit_slot_q;
  logic               ev_q;

  logic [CNT_W-1:0]       lru_count_q;
  logic [IMAGE_SLOTS-1:0] valid_q;
  logic [LIMIT_W-1:0]     limit_q;
  logic [MODE_W-1:0]      mode_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic               out_rv_q;
  logic [TEX_W-1:0]   out_tex_q;
  logic [ID_W-1:0]    out_img_q;
  logic               out_last_q;

  logic               ent_we;
  logic [SLOT_W-1:0]  ent_waddr, ent_raddr;
  entry_t             ent_wdata, ent_rdata;
  logic               lru_we;
  logic [SLOT_W-1:0]  lru_waddr, lru_raddr, lru_wdata, lru_rdata;

  logic               out_load;
  status_e            out_status;
  logic               out_rv;
  logic [TEX_W-1:0]   out_tex;
  logic [ID_W-1:0]    out_img;
  logic               out_last;

  logic               out_free;
  logic               over_limit;
  logic               scan_match, scan_free, lp_hit, resp_rv, clr_last;
  logic [SLOT_W-1:0]  cnt_idx;
  logic [IMAGE_SLOTS-1:0] valid_rest;
  logic [REFS_W-1:0]  refs_inc;

  ricl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(IMAGE_SLOTS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  ricl_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(IMAGE_SLOTS)
  ) u_lru_ram (
    .clk_i  (clk_i),
    .we_i   (lru_we),
    .waddr_i(lru_waddr),
    .wdata_i(lru_wdata),
    .raddr_i(lru_raddr),
    .rdata_o(lru_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign over_limit = (CMP_W'(lru_count_q) > CMP_W'(limit_q)) && (lru_count_q != '0);
  assign cnt_idx    = cnt_q[SLOT_W-1:0];
  assign scan_match = sc_vld_q && valid_q[sc_idx_q] && (ent_rdata.image == req_id_q);
  assign scan_free  = sc_vld_q && !valid_q[sc_idx_q];
  assign lp_hit     = lp_vld_q && !hit_q &&
                      (pass_head_q ? (lp_idx_q == '0) : (lru_rdata == found_slot_q));
  assign refs_inc   = (ent_q.refs == REFS_MAX) ? ent_q.refs : ent_q.refs + REFS_W'(1);

  always_comb begin
    valid_rest          = valid_q;
    valid_rest[cnt_idx] = 1'b0;
    clr_last            = (valid_rest == '0);
  end

  always_comb begin
    case (resp_st_q) inside
      STS_MISMATCH, STS_DUPLICATE, STS_FULL: resp_rv = 1'b1;
      default:                               resp_rv = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (req_e'(req_type_i))
            REQ_ASSIGN:  state_d = (image_mode_i != mode_q) ? S_RESP : S_SCAN;
            REQ_ACQUIRE: state_d = S_SCAN;
            REQ_RELEASE: state_d = S_SCAN;
            REQ_CLEAR:   state_d = (valid_q == '0) ? S_RESP : S_CLR_CHK;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_q == SLOTS_C && !sc_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (req_type_q)
          REQ_ASSIGN:  state_d = (!found_q && free_q) ? S_PUSH : S_RESP;
          REQ_ACQUIRE: state_d = (found_q && ent_q.refs == '0) ? S_LRU_PASS : S_RESP;
          REQ_RELEASE: state_d = (found_q && ent_q.refs == REFS_W'(1)) ? S_PUSH : S_RESP;
          default:     state_d = S_RESP;
        endcase
      end
      S_PUSH:      state_d = S_EVICT_CHK;
      S_EVICT_CHK: begin
        if (over_limit) begin
          state_d = S_LRU_PASS;
        end else begin
          state_d = ev_q ? S_IDLE : S_RESP;
        end
      end
      S_LRU_PASS: begin
        if (pos_q == lru_count_q && !lp_vld_q) begin
          state_d = pass_head_q ? S_EVICT_RD : S_RESP;
        end
      end
      S_EVICT_RD:   state_d = S_EVICT_EMIT;
      S_EVICT_EMIT: begin
        if (out_free) begin
          state_d = S_EVICT_CHK;
        end
      end
      S_CLR_CHK: begin
        if (valid_q[cnt_idx]) begin
          state_d = S_CLR_EMIT;
        end
      end
      S_CLR_EMIT: begin
        if (out_free) begin
          state_d = clr_last ? S_IDLE : S_CLR_CHK;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_ready_o = 1'b0;
    ent_we     = 1'b0;
    ent_waddr  = free_slot_q;
    ent_wdata  = '{image: req_id_q, texture: req_tex_q, refs: '0};
    ent_raddr  = (cnt_q < SLOTS_C) ? cnt_idx : '0;
    lru_we     = 1'b0;
    lru_waddr  = SLOT_W'(lp_idx_q - SLOT_W'(1));
    lru_wdata  = lru_rdata;
    lru_raddr  = (pos_q < lru_count_q) ? pos_q[SLOT_W-1:0] : '0;
    out_load   = 1'b0;
    out_status = STS_OK;
    out_rv     = 1'b1;
    out_tex    = ent_rdata.texture;
    out_img    = ent_rdata.image;
    out_last   = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_DECIDE: begin
        unique case (req_type_q)
          REQ_ASSIGN: ent_we = !found_q && free_q;
          REQ_ACQUIRE: begin
            ent_we    = found_q;
            ent_waddr = found_slot_q;
            ent_wdata = '{image: ent_q.image, texture: ent_q.texture, refs: refs_inc};
          end
          REQ_RELEASE: begin
            ent_we    = found_q && (ent_q.refs != '0);
            ent_waddr = found_slot_q;
            ent_wdata = '{image: ent_q.image, texture: ent_q.texture,
                          refs: ent_q.refs - REFS_W'(1)};
          end
          default: ent_we = 1'b0;
        endcase
      end
      S_PUSH: begin
        lru_we    = lru_count_q < SLOTS_C;
        lru_waddr = lru_count_q[SLOT_W-1:0];
        lru_wdata = push_slot_q;
      end
      S_LRU_PASS: lru_we = lp_vld_q && hit_q;
      S_EVICT_RD: ent_raddr = hit_slot_q;
      S_EVICT_EMIT: begin
        ent_raddr = hit_slot_q;
        out_load  = out_free;
        out_last  = !over_limit;
      end
      S_CLR_CHK: ent_raddr = cnt_idx;
      S_CLR_EMIT: begin
        ent_raddr = cnt_idx;
        out_load  = out_free;
        out_last  = clr_last;
      end
      S_RESP: begin
        out_load   = out_free;
        out_status = resp_st_q;
        out_rv     = resp_rv;
        out_tex    = resp_rv ? req_tex_q : '0;
        out_img    = (req_type_q == REQ_CLEAR) ? '0 : req_id_q;
        out_last   = 1'b1;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sc_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      pass_head_q <= 1'b0;
      pos_q       <= '0;
      lp_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      ev_q        <= 1'b0;
      lru_count_q <= '0;
      valid_q     <= '0;
      limit_q     <= LIMIT_RESET;
      mode_q      <= MODE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_LRU_LIMIT:    limit_q <= cfg_data_i[LIMIT_W-1:0];
          CFG_CURRENT_MODE: mode_q  <= cfg_data_i[MODE_W-1:0];
          default:          ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q    <= '0;
            sc_vld_q <= 1'b0;
            found_q  <= 1'b0;
            free_q   <= 1'b0;
            ev_q     <= 1'b0;
            if (req_e'(req_type_i) == REQ_CLEAR) begin
              lru_count_q <= '0;
            end
          end
        end
        S_SCAN: begin
          sc_vld_q <= cnt_q < SLOTS_C;
          if (cnt_q < SLOTS_C) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (scan_match) begin
            found_q <= 1'b1;
          end
          if (scan_free) begin
            free_q <= 1'b1;
          end
        end
        S_DECIDE: begin
          if (req_type_q == REQ_ASSIGN && !found_q && free_q) begin
            valid_q[free_slot_q] <= 1'b1;
          end
          pass_head_q <= 1'b0;
          pos_q       <= '0;
          lp_vld_q    <= 1'b0;
          hit_q       <= 1'b0;
        end
        S_PUSH: begin
          if (lru_count_q < SLOTS_C) begin
            lru_count_q <= lru_count_q + CNT_W'(1);
          end
        end
        S_EVICT_CHK: begin
          pass_head_q <= 1'b1;
          pos_q       <= '0;
          lp_vld_q    <= 1'b0;
          hit_q       <= 1'b0;
        end
        S_LRU_PASS: begin
          lp_vld_q <= pos_q < lru_count_q;
          if (pos_q < lru_count_q) begin
            pos_q <= pos_q + CNT_W'(1);
          end
          if (lp_hit) begin
            hit_q <= 1'b1;
          end
          if (pos_q == lru_count_q && !lp_vld_q && hit_q) begin
            lru_count_q <= lru_count_q - CNT_W'(1);
          end
        end
        S_EVICT_EMIT: begin
          if (out_free) begin
            valid_q[hit_slot_q] <= 1'b0;
            ev_q                <= 1'b1;
          end
        end
        S_CLR_CHK: begin
          if (!valid_q[cnt_idx]) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_CLR_EMIT: begin
          if (out_free) begin
            valid_q[cnt_idx] <= 1'b0;
            cnt_q            <= cnt_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status;
      out_rv_q     <= out_rv;
      out_tex_q    <= out_tex;
      out_img_q    <= out_img;
      out_last_q   <= out_last;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_type_q <= req_e'(req_type_i);
          req_id_q   <= image_id_i;
          req_tex_q  <= texture_id_i;
          resp_st_q  <= (req_e'(req_type_i) == REQ_ASSIGN && image_mode_i != mode_q) ?
                        STS_MISMATCH : STS_OK;
        end
      end
      S_SCAN: begin
        sc_idx_q <= cnt_idx;
        if (scan_match && !found_q) begin
          found_slot_q <= sc_idx_q;
          ent_q        <= ent_rdata;
        end
        if (scan_free && !free_q) begin
          free_slot_q <= sc_idx_q;
        end
      end
      S_DECIDE: begin
        push_slot_q <= (req_type_q == REQ_ASSIGN) ? free_slot_q : found_slot_q;
        unique case (req_type_q)
          REQ_ASSIGN: begin
            if (found_q) begin
              resp_st_q <= STS_DUPLICATE;
            end else if (!free_q) begin
              resp_st_q <= STS_FULL;
            end else begin
              resp_st_q <= STS_OK;
            end
          end
          REQ_ACQUIRE: resp_st_q <= found_q ? STS_OK : STS_UNKNOWN;
          REQ_RELEASE: begin
            if (!found_q) begin
              resp_st_q <= STS_UNKNOWN;
            end else if (ent_q.refs == '0) begin
              resp_st_q <= STS_UNDERFLOW;
            end else begin
              resp_st_q <= STS_OK;
            end
          end
          default: resp_st_q <= STS_OK;
        endcase
      end
      S_LRU_PASS: begin
        lp_idx_q <= pos_q[SLOT_W-1:0];
        if (lp_hit) begin
          hit_slot_q <= lru_rdata;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign release_valid_o    = out_rv_q;
  assign released_texture_o = out_tex_q;
  assign released_image_o   = out_img_q;
  assign last_o             = out_last_q;

endmodule

`default_nettype wire
